>>> rtl/core/slv_pkg.sv
// ----------------------------------------------------------------------------
// slv_pkg
// Shared constants for the 3x3 linear system solver.
// ----------------------------------------------------------------------------
package slv_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Operand pairs for the nine cofactors, adjugate order (row-major).
    // Entry 4k..4k+3 = p, q, r, s with adj[k] = a[p]*a[q] - a[r]*a[s].
    localparam logic [3:0] COF_IDX [36] = '{
        4'd4, 4'd8, 4'd5, 4'd7,
        4'd2, 4'd7, 4'd1, 4'd8,
        4'd1, 4'd5, 4'd2, 4'd4,
        4'd5, 4'd6, 4'd3, 4'd8,
        4'd0, 4'd8, 4'd2, 4'd6,
        4'd2, 4'd3, 4'd0, 4'd5,
        4'd3, 4'd7, 4'd4, 4'd6,
        4'd1, 4'd6, 4'd0, 4'd7,
        4'd0, 4'd4, 4'd1, 4'd3
    };

endpackage

>>> rtl/core/slv_in_if.sv
// ----------------------------------------------------------------------------
// slv_in_if
// Input channel: matrix A and right-hand side b, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slv_in_if #(
    parameter int WORD_BITS = slv_pkg::WORD_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] a00;
    logic signed [WORD_BITS-1:0] a01;
    logic signed [WORD_BITS-1:0] a02;
    logic signed [WORD_BITS-1:0] a10;
    logic signed [WORD_BITS-1:0] a11;
    logic signed [WORD_BITS-1:0] a12;
    logic signed [WORD_BITS-1:0] a20;
    logic signed [WORD_BITS-1:0] a21;
    logic signed [WORD_BITS-1:0] a22;
    logic signed [WORD_BITS-1:0] b0;
    logic signed [WORD_BITS-1:0] b1;
    logic signed [WORD_BITS-1:0] b2;

    modport source (
        output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, b0, b1, b2,
        input  ready
    );
    modport sink (
        input  valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, b0, b1, b2,
        output ready
    );
endinterface

>>> rtl/core/slv_out_if.sv
// ----------------------------------------------------------------------------
// slv_out_if
// Output channel: solution x and singular flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slv_out_if #(
    parameter int WORD_BITS = slv_pkg::WORD_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] x0;
    logic signed [WORD_BITS-1:0] x1;
    logic signed [WORD_BITS-1:0] x2;
    logic                        singular;

    modport source (output valid, x0, x1, x2, singular, input ready);
    modport sink   (input valid, x0, x1, x2, singular, output ready);
endinterface

>>> rtl/core/slv_cof.sv
// ----------------------------------------------------------------------------
// slv_cof
// Adjugate: 18 products in the first stage, nine differences in the second.
// ----------------------------------------------------------------------------
module slv_cof #(
    parameter int WORD_BITS = slv_pkg::WORD_BITS
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [WORD_BITS-1:0] a   [9],
    output logic signed [2*WORD_BITS:0] adj [9]
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;

    logic signed [PW-1:0] p_reg   [18];
    logic signed [PW-1:0] p_next  [18];
    logic signed [PW:0]   adj_reg [9];
    logic signed [PW:0]   adj_next[9];

    always_comb
    begin
        for (int k = 0; k < 18; k++)
        begin
            p_next[k] = a[slv_pkg::COF_IDX[2*k]] * a[slv_pkg::COF_IDX[2*k+1]];
        end
        for (int k = 0; k < 9; k++)
        begin
            adj_next[k] = $signed({p_reg[2*k][PW-1], p_reg[2*k]})
                        - $signed({p_reg[2*k+1][PW-1], p_reg[2*k+1]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg   <= p_next;
            adj_reg <= adj_next;
        end
    end

    assign adj = adj_reg;
endmodule

>>> rtl/core/slv_mac.sv
// ----------------------------------------------------------------------------
// slv_mac
// Three-term dot product of word-wide x and adjugate-wide y, three stages.
// y is split at WORD_BITS so every multiplier stays word by word+1.
// ----------------------------------------------------------------------------
module slv_mac #(
    parameter int WORD_BITS = slv_pkg::WORD_BITS
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [WORD_BITS-1:0]   x [3],
    input  logic signed [2*WORD_BITS:0]   y [3],
    output logic signed [3*WORD_BITS+2:0] s
);
    localparam int W  = WORD_BITS;
    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int EW = DW - AW;

    logic signed [AW-1:0] hi_reg [3];
    logic signed [AW-1:0] hi_next[3];
    logic signed [AW-1:0] lo_reg [3];
    logic signed [AW-1:0] lo_next[3];
    logic signed [DW-1:0] t_reg  [3];
    logic signed [DW-1:0] t_next [3];
    logic signed [DW-1:0] s_reg;
    logic signed [DW-1:0] s_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            hi_next[k] = x[k] * $signed(y[k][AW-1:W]);
            lo_next[k] = x[k] * $signed({1'b0, y[k][W-1:0]});
            t_next[k]  = ($signed({{EW{hi_reg[k][AW-1]}}, hi_reg[k]}) <<< W)
                       + $signed({{EW{lo_reg[k][AW-1]}}, lo_reg[k]});
        end
        s_next = t_reg[0] + t_reg[1] + t_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
            t_reg  <= t_next;
            s_reg  <= s_next;
        end
    end

    assign s = s_reg;
endmodule

>>> rtl/core/slv_div.sv
// ----------------------------------------------------------------------------
// slv_div
// Signed scaled divide: (num << FRAC_BITS) / den, truncated toward zero and
// saturated. Two setup stages, one restoring step per quotient bit, one
// saturation stage.
// ----------------------------------------------------------------------------
module slv_div #(
    parameter int WORD_BITS = slv_pkg::WORD_BITS,
    parameter int FRAC_BITS = slv_pkg::FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [3*WORD_BITS+2:0] num,
    input  logic signed [3*WORD_BITS+2:0] den,
    output logic        [WORD_BITS-1:0]   q,
    output logic                          zero
);
    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DW = 3 * W + 3;
    localparam int CW = DW + F;

    // setup stage 1: magnitudes
    logic          neg1_reg, neg1_next, zero1_reg, zero1_next;
    logic [DW-1:0] nmag1_reg, nmag1_next, dmag1_reg, dmag1_next;

    // step pipeline, index 0 loaded by setup stage 2
    logic [DW-1:0] rem_reg  [W+1];
    logic [DW-1:0] rem_next [W+1];
    logic [W-1:0]  low_reg  [W+1];
    logic [W-1:0]  low_next [W+1];
    logic [W-1:0]  quo_reg  [W+1];
    logic [W-1:0]  quo_next [W+1];
    logic [DW-1:0] dmag_reg [W+1];
    logic [DW-1:0] dmag_next[W+1];
    logic [W:0]    neg_reg, neg_next, big_reg, big_next, zero_reg, zero_next;

    logic [CW-1:0] nsh;
    logic [CW-1:0] nhi;
    logic [DW:0]   trial;
    logic          ge;
    logic [W-1:0]  m;
    logic          pos_sat, neg_sat;
    logic [W-1:0]  q_reg, q_next;
    logic          qz_reg;

    always_comb
    begin
        neg1_next  = num[DW-1] ^ den[DW-1];
        zero1_next = (den == '0);
        nmag1_next = num[DW-1] ? DW'(-num) : DW'(num);
        dmag1_next = den[DW-1] ? DW'(-den) : DW'(den);

        nsh = CW'(nmag1_reg) << F;
        nhi = nsh >> W;
        big_next[0]  = (nhi >= CW'(dmag1_reg));
        rem_next[0]  = big_next[0] ? '0 : DW'(nhi);
        low_next[0]  = nsh[W-1:0];
        quo_next[0]  = '0;
        dmag_next[0] = dmag1_reg;
        neg_next[0]  = neg1_reg;
        zero_next[0] = zero1_reg;

        trial = '0;
        ge    = 1'b0;
        for (int s = 0; s < W; s++)
        begin
            trial = {rem_reg[s], low_reg[s][W-1]};
            ge    = (trial >= {1'b0, dmag_reg[s]});
            rem_next[s+1]  = ge ? DW'(trial - {1'b0, dmag_reg[s]}) : DW'(trial);
            low_next[s+1]  = low_reg[s] << 1;
            quo_next[s+1]  = {quo_reg[s][W-2:0], ge};
            dmag_next[s+1] = dmag_reg[s];
            neg_next[s+1]  = neg_reg[s];
            big_next[s+1]  = big_reg[s];
            zero_next[s+1] = zero_reg[s];
        end

        m       = quo_reg[W];
        pos_sat = big_reg[W] || m[W-1];
        neg_sat = big_reg[W] || (m[W-1] && (|m[W-2:0]));
        if (zero_reg[W])
            q_next = '0;
        else if (neg_reg[W])
            q_next = neg_sat ? {1'b1, {(W-1){1'b0}}} : W'(-m);
        else
            q_next = pos_sat ? {1'b0, {(W-1){1'b1}}} : m;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= neg1_next;
            zero1_reg <= zero1_next;
            nmag1_reg <= nmag1_next;
            dmag1_reg <= dmag1_next;
            rem_reg   <= rem_next;
            low_reg   <= low_next;
            quo_reg   <= quo_next;
            dmag_reg  <= dmag_next;
            neg_reg   <= neg_next;
            big_reg   <= big_next;
            zero_reg  <= zero_next;
            q_reg     <= q_next;
            qz_reg    <= zero_reg[W];
        end
    end

    assign q    = q_reg;
    assign zero = qz_reg;
endmodule

>>> rtl/core/linear_solve_3x3_top.sv
// ----------------------------------------------------------------------------
// linear_solve_3x3_top
// Solves A x = b for one 3x3 system per item, Q16.16 by default.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock unless the output stalls. Two
// stages form the adjugate, three form the determinant and the adj(A)*b
// numerators, and each of three divider lanes has two setup stages, one
// step per quotient bit and one saturation stage. The divider chain is the
// longest part of the pipeline. A stalled output freezes the whole
// pipeline; nothing is dropped. A zero determinant gives x = 0 with
// singular set.
module linear_solve_3x3_top #(
    parameter int WORD_BITS = slv_pkg::WORD_BITS,
    parameter int FRAC_BITS = slv_pkg::FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    slv_in_if.sink     req,
    slv_out_if.source  rsp
);
    localparam int W   = WORD_BITS;
    localparam int AW  = 2 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int LAT = W + 8;

    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;

    logic signed [W-1:0]  a_in   [9];
    logic signed [AW-1:0] adj    [9];
    logic signed [W-1:0]  row_reg[2][3];
    logic signed [W-1:0]  b_reg  [2][3];
    logic signed [AW-1:0] det_y  [3];
    logic signed [DW-1:0] det;
    logic signed [DW-1:0] num    [3];
    logic        [W-1:0]  q      [3];
    logic                 zero   [3];

    assign en        = !vld_reg[LAT-1] || rsp.ready;
    assign req.ready = en;
    assign rsp.valid = vld_reg[LAT-1];
    assign vld_next  = {vld_reg[LAT-2:0], req.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    assign a_in[0] = req.a00;
    assign a_in[1] = req.a01;
    assign a_in[2] = req.a02;
    assign a_in[3] = req.a10;
    assign a_in[4] = req.a11;
    assign a_in[5] = req.a12;
    assign a_in[6] = req.a20;
    assign a_in[7] = req.a21;
    assign a_in[8] = req.a22;

    slv_cof #(.WORD_BITS(W)) u_cof (
        .clk (clk),
        .en  (en),
        .a   (a_in),
        .adj (adj)
    );

    // row 0 and b pass through two registers to line up with the adjugate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg[0] <= '{a_in[0], a_in[1], a_in[2]};
            row_reg[1] <= row_reg[0];
            b_reg[0]   <= '{req.b0, req.b1, req.b2};
            b_reg[1]   <= b_reg[0];
        end
    end

    assign det_y[0] = adj[0];
    assign det_y[1] = adj[3];
    assign det_y[2] = adj[6];

    slv_mac #(.WORD_BITS(W)) u_mac_det (
        .clk (clk),
        .en  (en),
        .x   (row_reg[1]),
        .y   (det_y),
        .s   (det)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        logic signed [AW-1:0] num_y [3];

        assign num_y[0] = adj[3*i];
        assign num_y[1] = adj[3*i+1];
        assign num_y[2] = adj[3*i+2];

        slv_mac #(.WORD_BITS(W)) u_mac (
            .clk (clk),
            .en  (en),
            .x   (b_reg[1]),
            .y   (num_y),
            .s   (num[i])
        );

        slv_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
            .clk  (clk),
            .en   (en),
            .num  (num[i]),
            .den  (det),
            .q    (q[i]),
            .zero (zero[i])
        );
    end

    assign rsp.x0       = $signed(q[0]);
    assign rsp.x1       = $signed(q[1]);
    assign rsp.x2       = $signed(q[2]);
    assign rsp.singular = zero[0];

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp.valid |-> req.ready)
        else $error("input stalled with empty output stage");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.singular |-> rsp.x0 == '0 && rsp.x1 == '0 && rsp.x2 == '0)
        else $error("singular item with nonzero solution");

    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> zero[0] == zero[1] && zero[1] == zero[2])
        else $error("divider lanes disagree on zero determinant");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");
endmodule
